/* design/e2q_pkg.sv */
// Shared constants and arithmetic helpers for the Euler angle to quaternion block.
// Holds the CORDIC arctangent table, the gain constant and the rounded Q30 multiply.
// Depends on nothing else in the project.
package e2q_pkg;

  // Default widths of the angle inputs and the quaternion outputs.
  localparam int DEF_ANGLE_BITS     = 16;
  localparam int DEF_COMPONENT_BITS = 16;

  // Number of CORDIC micro-rotations, one pipeline stage each.
  localparam int CORDIC_STEPS = 24;

  // Cosine and sine in Q2.30, carried with one spare bit.
  localparam int CS_W   = 33;
  // Residual angle, 2^33 units per turn, with headroom for the first steps.
  localparam int Z_W    = 34;
  // Full product of two CS_W operands.
  localparam int PROD_W = 2 * CS_W;

  // Initial x of the CORDIC: the inverse of its gain, in Q2.30.
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // Zero-valued start for the y register of the CORDIC.
  localparam logic signed [CS_W-1:0] CS_ZERO = '0;

  // atan(2^-i) in units of 2^33 per turn.
  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd1073741824, 34'sd633866812, 34'sd334917814, 34'sd170009512,
    34'sd85334662,   34'sd42708930,  34'sd21359676,  34'sd10680490,
    34'sd5340326,    34'sd2670174,   34'sd1335088,   34'sd667544,
    34'sd333772,     34'sd166886,    34'sd83444,     34'sd41722,
    34'sd20860,      34'sd10432,     34'sd5216,      34'sd2608,
    34'sd1304,       34'sd652,       34'sd326,       34'sd162
  };

  // Half an LSB of Q30, added before the final shift of a product.
  localparam logic signed [PROD_W-1:0] HALF_Q30 = PROD_W'(1) << 29;

  // Product of two Q30 values, rounded half up back to Q30.
  function automatic logic signed [CS_W-1:0] mul_q30(input logic signed [CS_W-1:0] a,
                                                      input logic signed [CS_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = a * b + HALF_Q30;
    return p[30 +: CS_W];
  endfunction

endpackage

/* design/euler_to_quaternion.sv */
// Top level of the Euler angle (Z-Y-X) to unit quaternion converter.
// Holds the CORDIC pipeline, the two product stages, the sum and the output rounding.
// Depends on e2q_pkg for its constants and the rounded Q30 multiply.
//
// Usage: the sender drives roll_angle, pitch_angle and yaw_angle (signed binary angles,
// 2^(ANGLE_BITS-1) equals pi) and raises start. A beat is taken at every rising edge
// where start is high and busy is low. busy is high only while rst is asserted, so
// outside reset one beat can enter in every cycle.
//
// Each accepted beat yields exactly one result beat: quat_w, quat_x, quat_y and quat_z
// (signed Q1.(COMPONENT_BITS-1), rounded and saturated) are presented together with
// done, high for exactly one cycle. On its way the beat passes one input register,
// 24 CORDIC stages (one micro-rotation each, three angles in parallel), two multiplier
// stages, a sum stage and the rounding output register.
// Throughput is one beat per cycle.
//
// The receiver cannot stall, so nothing is held back. Synchronous reset clears every
// valid bit in the pipeline; beats in flight at reset are dropped and done stays low
// until a beat accepted after reset reaches the output.
module euler_to_quaternion #(
  parameter int ANGLE_BITS     = e2q_pkg::DEF_ANGLE_BITS,
  parameter int COMPONENT_BITS = e2q_pkg::DEF_COMPONENT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [ANGLE_BITS-1:0]     roll_angle,
  input  logic signed [ANGLE_BITS-1:0]     pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]     yaw_angle,
  output logic                             done,
  output logic signed [COMPONENT_BITS-1:0] quat_w,
  output logic signed [COMPONENT_BITS-1:0] quat_x,
  output logic signed [COMPONENT_BITS-1:0] quat_y,
  output logic signed [COMPONENT_BITS-1:0] quat_z
);
  import e2q_pkg::*;

  // Shift that turns an input angle into a half angle with 2^33 units per turn.
  localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;

  // Axis and component indexes.
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;
  localparam int NUM_AXES = 3;
  localparam int QW = 0;
  localparam int QX = 1;
  localparam int QY = 2;
  localparam int QZ = 3;
  localparam int NUM_COMP = 4;

  // Output rounding from Q30 to FRAC fraction bits.
  localparam int FRAC  = COMPONENT_BITS - 1;
  localparam int RSH   = (FRAC < 30) ? (30 - FRAC) : 1;
  localparam int SUM_W = CS_W + 1;
  localparam int R_W   = CS_W + 3;
  localparam logic signed [R_W-1:0] RND_HALF = R_W'(1) << (RSH - 1);
  localparam logic signed [R_W-1:0] SAT_HI   = (R_W'(1) << FRAC) - R_W'(1);
  localparam logic signed [R_W-1:0] SAT_LO   = -SAT_HI - R_W'(1);

  // Cycles from the accepting edge to the edge that loads the output register.
  localparam int LATENCY = CORDIC_STEPS + 4;

  // The pipeline never stalls; beats are refused only during reset.
  assign busy = rst;

  // ------------------------------------------------------------------------
  // Input register and CORDIC pipeline. Stage 0 holds the start vector and the
  // half angles; stage i+1 holds the vectors after micro-rotation i.
  // ------------------------------------------------------------------------
  logic                    cvld [CORDIC_STEPS+1];
  logic signed [CS_W-1:0]  cx   [CORDIC_STEPS+1][NUM_AXES];
  logic signed [CS_W-1:0]  cy   [CORDIC_STEPS+1][NUM_AXES];
  logic signed [Z_W-1:0]   cz   [CORDIC_STEPS+1][NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld[0] <= 1'b0;
    end else begin
      cvld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      cx[0][a] <= CORDIC_GAIN;
      cy[0][a] <= CS_ZERO;
    end
    // Sign-extend, then scale so that the input's pi becomes a quarter turn.
    cz[0][AX_ROLL]  <= Z_W'(roll_angle) <<< ANGLE_SHIFT;
    cz[0][AX_PITCH] <= Z_W'(pitch_angle) <<< ANGLE_SHIFT;
    cz[0][AX_YAW]   <= Z_W'(yaw_angle) <<< ANGLE_SHIFT;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[i+1] <= 1'b0;
      end else begin
        cvld[i+1] <= cvld[i];
      end
    end

    always_ff @(posedge clk) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        // Rotate toward a zero residual angle; both updates use the old x and y.
        if (cz[i][a] >= 0) begin
          cx[i+1][a] <= cx[i][a] - (cy[i][a] >>> i);
          cy[i+1][a] <= cy[i][a] + (cx[i][a] >>> i);
          cz[i+1][a] <= cz[i][a] - ATAN_TAB[i];
        end else begin
          cx[i+1][a] <= cx[i][a] + (cy[i][a] >>> i);
          cy[i+1][a] <= cy[i][a] - (cx[i][a] >>> i);
          cz[i+1][a] <= cz[i][a] + ATAN_TAB[i];
        end
      end
    end
  end

  // Final cosines and sines of the half angles.
  logic signed [CS_W-1:0] cos_r, sin_r, cos_p, sin_p, cos_y, sin_y;
  assign cos_r = cx[CORDIC_STEPS][AX_ROLL];
  assign sin_r = cy[CORDIC_STEPS][AX_ROLL];
  assign cos_p = cx[CORDIC_STEPS][AX_PITCH];
  assign sin_p = cy[CORDIC_STEPS][AX_PITCH];
  assign cos_y = cx[CORDIC_STEPS][AX_YAW];
  assign sin_y = cy[CORDIC_STEPS][AX_YAW];

  // ------------------------------------------------------------------------
  // First product stage: roll times pitch; the yaw terms ride along.
  // ------------------------------------------------------------------------
  logic                   m1_vld;
  logic signed [CS_W-1:0] m1_crcp, m1_srsp, m1_crsp, m1_srcp, m1_cy, m1_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= cvld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    m1_crcp <= mul_q30(cos_r, cos_p);
    m1_srsp <= mul_q30(sin_r, sin_p);
    m1_crsp <= mul_q30(cos_r, sin_p);
    m1_srcp <= mul_q30(sin_r, cos_p);
    m1_cy   <= cos_y;
    m1_sy   <= sin_y;
  end

  // ------------------------------------------------------------------------
  // Second product stage: the eight triple products, two per component.
  // ------------------------------------------------------------------------
  logic                   m2_vld;
  logic signed [CS_W-1:0] m2_a [NUM_COMP];
  logic signed [CS_W-1:0] m2_b [NUM_COMP];

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    m2_a[QW] <= mul_q30(m1_crcp, m1_cy);
    m2_b[QW] <= mul_q30(m1_srsp, m1_sy);
    m2_a[QX] <= mul_q30(m1_srcp, m1_cy);
    m2_b[QX] <= mul_q30(m1_crsp, m1_sy);
    m2_a[QY] <= mul_q30(m1_crsp, m1_cy);
    m2_b[QY] <= mul_q30(m1_srcp, m1_sy);
    m2_a[QZ] <= mul_q30(m1_crcp, m1_sy);
    m2_b[QZ] <= mul_q30(m1_srsp, m1_cy);
  end

  // ------------------------------------------------------------------------
  // Sum stage: w and y add their terms, x and z subtract the second one.
  // ------------------------------------------------------------------------
  logic                    sum_vld;
  logic signed [SUM_W-1:0] sum_q [NUM_COMP];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    sum_q[QW] <= SUM_W'(m2_a[QW]) + SUM_W'(m2_b[QW]);
    sum_q[QX] <= SUM_W'(m2_a[QX]) - SUM_W'(m2_b[QX]);
    sum_q[QY] <= SUM_W'(m2_a[QY]) + SUM_W'(m2_b[QY]);
    sum_q[QZ] <= SUM_W'(m2_a[QZ]) - SUM_W'(m2_b[QZ]);
  end

  // ------------------------------------------------------------------------
  // Output stage: round to the component format, saturate, register.
  // ------------------------------------------------------------------------
  logic signed [COMPONENT_BITS-1:0] comp_next [NUM_COMP];
  logic signed [COMPONENT_BITS-1:0] comp      [NUM_COMP];

  always_comb begin
    logic signed [R_W-1:0] rs;
    logic signed [R_W-1:0] rv;
    for (int k = 0; k < NUM_COMP; k++) begin
      rs = R_W'(sum_q[k]);
      if (FRAC < 30) begin
        rv = (rs + RND_HALF) >>> RSH;
      end else if (FRAC == 30) begin
        rv = rs;
      end else begin
        rv = rs <<< 1;
      end
      // CORDIC and rounding error can overshoot +1 or -1 by a hair.
      if (rv > SAT_HI) begin
        rv = SAT_HI;
      end else if (rv < SAT_LO) begin
        rv = SAT_LO;
      end
      comp_next[k] = rv[COMPONENT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_COMP; k++) begin
      comp[k] <= comp_next[k];
    end
  end

  assign quat_w = comp[QW];
  assign quat_x = comp[QX];
  assign quat_y = comp[QY];
  assign quat_z = comp[QZ];

  // ------------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------------

  // A result beat is only ever the product of an accepted beat: the check looks back from
  // each edge that samples done high to the edge that accepted its beat.
  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY + 1))
    else $error("result beat without a matching accepted beat");

  // Reset flushes the pipeline: no result beat right after reset.
  a_reset_flush: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done)
    else $error("result beat directly after reset");

  // The pipeline never refuses a beat outside reset.
  a_never_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy raised outside reset");

endmodule
